// ----- rtl/htli_pkg.sv -----
// Shared types, register map and timing constants for the timer, LCD timing and interrupt unit.
`default_nettype none

package htli_pkg;

  // Request codes carried on the input channel.
  typedef enum logic [1:0] {
    REQ_ADVANCE = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_READ    = 2'd2,
    REQ_IDLE    = 2'd3
  } req_t;

  // I/O register map, low byte of the address in page FF00.
  localparam logic [7:0] ADDR_DIV  = 8'h04;
  localparam logic [7:0] ADDR_TIMA = 8'h05;
  localparam logic [7:0] ADDR_TMA  = 8'h06;
  localparam logic [7:0] ADDR_TAC  = 8'h07;
  localparam logic [7:0] ADDR_IF   = 8'h0F;
  localparam logic [7:0] ADDR_LCDC = 8'h40;
  localparam logic [7:0] ADDR_STAT = 8'h41;
  localparam logic [7:0] ADDR_LY   = 8'h44;
  localparam logic [7:0] ADDR_LYC  = 8'h45;
  localparam logic [7:0] ADDR_IE   = 8'hFF;

  localparam logic [7:0] UNMAPPED_READ = 8'hFF;
  localparam logic [7:0] LCDC_RESET    = 8'h91;

  // LCD line timing, in machine cycles and lines.
  localparam logic [7:0] LAST_LINE       = 8'd153;
  localparam logic [7:0] VBLANK_LINE     = 8'd144;
  localparam logic [7:0] CYCLES_PER_LINE = 8'd114;
  localparam logic [7:0] HBLANK_START    = 8'd63;
  localparam logic [7:0] DRAW_START      = 8'd20;

  // STAT mode codes.
  localparam logic [1:0] MODE_HBLANK = 2'b00;
  localparam logic [1:0] MODE_VBLANK = 2'b01;
  localparam logic [1:0] MODE_OAM    = 2'b10;
  localparam logic [1:0] MODE_DRAW   = 2'b11;

  // Interrupt vectors: base plus eight times the request bit.
  localparam logic [6:0] VECTOR_BASE = 7'h40;
  localparam int unsigned IRQ_COUNT  = 5;

  // Control for one committed item, shared by all units.
  typedef struct packed {
    logic       adv;
    logic       wr;
    logic [7:0] addr;
    logic [7:0] data;
    logic [2:0] mc;
    logic       dbl;
    logic       ime;
  } htli_ctl_t;

  typedef struct packed {
    logic       stat_req;
    logic       vblank;
    logic       vblank_stat;
  } line_evt_t;

  typedef struct packed {
    logic [7:0] lcdc;
    logic [7:0] stat;
    logic [7:0] ly;
    logic [7:0] lyc;
  } line_regs_t;

  typedef struct packed {
    logic [7:0] div;
    logic [7:0] tima;
    logic [7:0] tma;
    logic [7:0] tac;
  } tmr_regs_t;

  // Timer period selected by TAC bits 1..0.
  function automatic logic [15:0] timer_period(input logic [1:0] sel);
    logic [15:0] p;
    unique case (sel)
      2'd0: p = 16'd1024;
      2'd1: p = 16'd16;
      2'd2: p = 16'd64;
      2'd3: p = 16'd256;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/htli_line.sv -----
// LCD line counter: STAT mode, LY, LYC compare and line requests.
`default_nettype none

module htli_line (
  input  wire                    clk,
  input  wire                    rst_n,
  input  htli_pkg::htli_ctl_t    ctl,
  output htli_pkg::line_evt_t    evt,
  output htli_pkg::line_regs_t   regs
);
  import htli_pkg::*;

  logic [7:0] line_acc_r, line_acc_nxt;
  logic [7:0] ly_r, ly_nxt;
  logic [7:0] lyc_r, lyc_nxt;
  logic [7:0] stat_r, stat_nxt;
  logic [7:0] lcdc_r, lcdc_nxt;

  logic [7:0] la_sum;
  logic [1:0] mode;
  logic [7:0] st;
  logic [7:0] ly_inc;
  logic       line_done;
  logic       match;

  always_comb begin
    la_sum = line_acc_r + {5'b0, ctl.mc};
    if (ly_r >= VBLANK_LINE) begin
      mode = MODE_VBLANK;
    end else if (la_sum >= HBLANK_START) begin
      mode = MODE_HBLANK;
    end else if (la_sum >= DRAW_START) begin
      mode = MODE_DRAW;
    end else begin
      mode = MODE_OAM;
    end
    st        = {stat_r[7:2], mode};
    line_done = la_sum >= CYCLES_PER_LINE;
    ly_inc    = (ly_r == LAST_LINE) ? 8'd0 : ly_r + 8'd1;
    match     = ly_inc == lyc_r;
  end

  always_comb begin
    line_acc_nxt    = line_acc_r;
    ly_nxt          = ly_r;
    lyc_nxt         = lyc_r;
    stat_nxt        = stat_r;
    lcdc_nxt        = lcdc_r;
    evt.stat_req    = 1'b0;
    evt.vblank      = 1'b0;
    evt.vblank_stat = st[4];
    if (ctl.adv) begin
      line_acc_nxt = la_sum;
      stat_nxt     = st;
      if (line_done) begin
        if (lcdc_r[7]) begin
          ly_nxt       = ly_inc;
          line_acc_nxt = la_sum - CYCLES_PER_LINE;
          stat_nxt     = {st[7:3], match, st[1:0]};
          evt.stat_req = st[3] | st[5] | (st[6] & match);
          evt.vblank   = ly_inc == VBLANK_LINE;
        end else begin
          ly_nxt = 8'd0;
        end
      end
    end else if (ctl.wr) begin
      if (ctl.addr == ADDR_LCDC) begin
        lcdc_nxt = ctl.data;
      end
      if (ctl.addr == ADDR_STAT) begin
        stat_nxt = {1'b0, ctl.data[6:3], stat_r[2:0]};
      end
      if (ctl.addr == ADDR_LYC) begin
        lyc_nxt = ctl.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_acc_r <= 8'd0;
      ly_r       <= 8'd0;
      lyc_r      <= 8'd0;
      stat_r     <= 8'd0;
      lcdc_r     <= LCDC_RESET;
    end else begin
      line_acc_r <= line_acc_nxt;
      ly_r       <= ly_nxt;
      lyc_r      <= lyc_nxt;
      stat_r     <= stat_nxt;
      lcdc_r     <= lcdc_nxt;
    end
  end

  assign regs.lcdc = lcdc_r;
  assign regs.stat = stat_r;
  assign regs.ly   = ly_r;
  assign regs.lyc  = lyc_r;

endmodule

`default_nettype wire

// ----- rtl/htli_timer.sv -----
// Divider and selectable timer with reload and overflow request.
`default_nettype none

module htli_timer (
  input  wire                   clk,
  input  wire                   rst_n,
  input  htli_pkg::htli_ctl_t   ctl,
  output logic                  ovf,
  output htli_pkg::tmr_regs_t   regs
);
  import htli_pkg::*;

  // The divider accumulator stays below 256 after each step, so eight bits hold it.
  logic [7:0]  div_acc_r, div_acc_nxt;
  logic [15:0] tmr_acc_r, tmr_acc_nxt;
  logic [7:0]  div_r, div_nxt;
  logic [7:0]  tima_r, tima_nxt;
  logic [7:0]  tma_r, tma_nxt;
  logic [7:0]  tac_r, tac_nxt;

  logic [3:0]  scaled;
  logic [8:0]  div_sum;
  logic [15:0] tmr_sum;
  logic [15:0] period;
  logic        fire;

  always_comb begin
    scaled  = ctl.dbl ? {ctl.mc, 1'b0} : {1'b0, ctl.mc};
    div_sum = {1'b0, div_acc_r} + {5'b0, scaled};
    tmr_sum = tmr_acc_r + {12'b0, scaled};
    period  = timer_period(tac_r[1:0]);
    fire    = tac_r[2] && (tmr_sum >= period);
  end

  always_comb begin
    div_acc_nxt = div_acc_r;
    tmr_acc_nxt = tmr_acc_r;
    div_nxt     = div_r;
    tima_nxt    = tima_r;
    tma_nxt     = tma_r;
    tac_nxt     = tac_r;
    ovf         = 1'b0;
    if (ctl.adv) begin
      div_acc_nxt = div_sum[7:0];
      if (div_sum[8]) begin
        div_nxt = div_r + 8'd1;
      end
      tmr_acc_nxt = tmr_sum;
      if (fire) begin
        tmr_acc_nxt = tmr_sum - period;
        if (tima_r == 8'hFF) begin
          tima_nxt = tma_r;
          ovf      = 1'b1;
        end else begin
          tima_nxt = tima_r + 8'd1;
        end
      end
    end else if (ctl.wr) begin
      if (ctl.addr == ADDR_DIV) begin
        div_nxt = 8'd0;
      end
      if (ctl.addr == ADDR_TIMA) begin
        tima_nxt = ctl.data;
      end
      if (ctl.addr == ADDR_TMA) begin
        tma_nxt = ctl.data;
      end
      if (ctl.addr == ADDR_TAC) begin
        tac_nxt = ctl.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_acc_r <= 8'd0;
      tmr_acc_r <= 16'd0;
      div_r     <= 8'd0;
      tima_r    <= 8'd0;
      tma_r     <= 8'd0;
      tac_r     <= 8'd0;
    end else begin
      div_acc_r <= div_acc_nxt;
      tmr_acc_r <= tmr_acc_nxt;
      div_r     <= div_nxt;
      tima_r    <= tima_nxt;
      tma_r     <= tma_nxt;
      tac_r     <= tac_nxt;
    end
  end

  assign regs.div  = div_r;
  assign regs.tima = tima_r;
  assign regs.tma  = tma_r;
  assign regs.tac  = tac_r;

endmodule

`default_nettype wire

// ----- rtl/htli_irq.sv -----
// Interrupt flag and enable registers, priority dispatch and halt wake.
`default_nettype none

module htli_irq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  htli_pkg::htli_ctl_t   ctl,
  input  htli_pkg::line_evt_t   evt,
  input  wire                   tmr_ovf,
  output logic                  taken,
  output logic [6:0]            vector,
  output logic                  wake,
  output logic [7:0]            flag,
  output logic [7:0]            ie
);
  import htli_pkg::*;

  logic [7:0] flag_r, flag_nxt;
  logic [7:0] ie_r, ie_nxt;

  logic [7:0]           raised;
  logic [7:0]           fl;
  logic [IRQ_COUNT-1:0] pend;
  logic [2:0]           sel;
  logic [7:0]           clr_mask;

  always_comb begin
    raised = {5'b0, tmr_ovf, evt.stat_req | (evt.vblank & evt.vblank_stat), evt.vblank};
    fl     = flag_r | raised;
    pend   = fl[IRQ_COUNT-1:0] & ie_r[IRQ_COUNT-1:0];
    // Lowest set bit wins.
    sel    = 3'd0;
    for (int i = IRQ_COUNT - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = 3'(i);
      end
    end
    taken    = ctl.adv && ctl.ime && (pend != '0);
    clr_mask = taken ? (8'd1 << sel) : 8'd0;
    vector   = taken ? (VECTOR_BASE + {1'b0, sel, 3'b000}) : 7'd0;
    wake     = ctl.adv && ((evt.stat_req & ie_r[1])
             | (evt.vblank & (ie_r[0] | (ie_r[1] & evt.vblank_stat)))
             | (tmr_ovf & ie_r[2])
             | taken);
  end

  always_comb begin
    flag_nxt = flag_r;
    ie_nxt   = ie_r;
    if (ctl.adv) begin
      flag_nxt = fl & ~clr_mask;
    end else if (ctl.wr) begin
      if (ctl.addr == ADDR_IF) begin
        flag_nxt = ctl.data;
      end
      if (ctl.addr == ADDR_IE) begin
        ie_nxt = ctl.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 8'd0;
      ie_r   <= 8'd0;
    end else begin
      flag_r <= flag_nxt;
      ie_r   <= ie_nxt;
    end
  end

  assign flag = flag_r;
  assign ie   = ie_r;

endmodule

`default_nettype wire

// ----- rtl/handheld_timer_lcd_timing_irq_unit.sv -----
// Top level of the timer, LCD line timing and interrupt unit.
`default_nettype none

// This block models the divider, the selectable timer, the LCD line counter and the
// interrupt controller of a handheld console. Each input transfer is a register read,
// a register write, or an advance by a few machine cycles, and each one yields exactly
// one result transfer carrying read data, the dispatched interrupt and the wake flag.
// An item is captured in an input register, its whole effect on the timer, line and
// interrupt state is computed in short combinational logic, and the state and a result
// register are updated together at the edge that moves it out. A new item is taken
// every cycle while the result side does not stall: the result is registered in the
// result register as the item leaves the input register, and the sustained rate is
// one item per clock, limited only by stall on the result side. The result register
// parts the two channels, so an item can wait in the input register while a finished
// result waits to be taken. Reads of unmapped addresses return 0xFF, request code 3
// returns an all-zero result and changes nothing.

module handheld_timer_lcd_timing_irq_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] in_req_type,
  input  wire  [7:0] in_reg_addr,
  input  wire  [7:0] in_write_data,
  input  wire  [2:0] in_machine_cycles,
  input  wire        in_double_speed,
  input  wire        in_master_enable,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq_taken,
  output logic [6:0] out_irq_vector,
  output logic       out_wake
);
  import htli_pkg::*;

  // Input register.
  logic       s1_valid_r, s1_valid_nxt;
  req_t       s1_req_r;
  logic [7:0] s1_addr_r;
  logic [7:0] s1_data_r;
  logic [2:0] s1_mc_r;
  logic       s1_dbl_r;
  logic       s1_ime_r;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_read_data_r;
  logic       out_irq_taken_r;
  logic [6:0] out_irq_vector_r;
  logic       out_wake_r;

  logic       in_take;
  logic       slot_free;
  logic       commit;
  logic       is_adv;
  logic       is_wr;
  logic       is_rd;
  logic [7:0] rd_val;

  htli_ctl_t  ctl;
  line_evt_t  line_evt;
  line_regs_t line_regs;
  tmr_regs_t  tmr_regs;
  logic       tmr_ovf;
  logic       irq_taken;
  logic [6:0] irq_vector;
  logic       irq_wake;
  logic [7:0] irq_flag;
  logic [7:0] irq_ie;

  // The held item moves on when the result register is empty or being emptied.
  assign slot_free = !out_valid_r || !out_stall;
  assign commit    = s1_valid_r && slot_free;
  assign in_stall  = s1_valid_r && !slot_free;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    is_adv = 1'b0;
    is_wr  = 1'b0;
    is_rd  = 1'b0;
    unique case (s1_req_r)
      REQ_ADVANCE: is_adv = 1'b1;
      REQ_WRITE:   is_wr  = 1'b1;
      REQ_READ:    is_rd  = 1'b1;
      REQ_IDLE:    ;
    endcase
  end

  // State changes only at the edge where the item leaves the input register.
  always_comb begin
    ctl.adv  = commit && is_adv;
    ctl.wr   = commit && is_wr;
    ctl.addr = s1_addr_r;
    ctl.data = s1_data_r;
    ctl.mc   = s1_mc_r;
    ctl.dbl  = s1_dbl_r;
    ctl.ime  = s1_ime_r;
  end

  htli_line u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .evt   (line_evt),
    .regs  (line_regs)
  );

  htli_timer u_timer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .ovf   (tmr_ovf),
    .regs  (tmr_regs)
  );

  htli_irq u_irq (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .evt     (line_evt),
    .tmr_ovf (tmr_ovf),
    .taken   (irq_taken),
    .vector  (irq_vector),
    .wake    (irq_wake),
    .flag    (irq_flag),
    .ie      (irq_ie)
  );

  // Register read mux; reads see the state before this item.
  always_comb begin
    unique case (s1_addr_r)
      ADDR_DIV:  rd_val = tmr_regs.div;
      ADDR_TIMA: rd_val = tmr_regs.tima;
      ADDR_TMA:  rd_val = tmr_regs.tma;
      ADDR_TAC:  rd_val = tmr_regs.tac;
      ADDR_IF:   rd_val = irq_flag;
      ADDR_LCDC: rd_val = line_regs.lcdc;
      ADDR_STAT: rd_val = line_regs.stat;
      ADDR_LY:   rd_val = line_regs.ly;
      ADDR_LYC:  rd_val = line_regs.lyc;
      ADDR_IE:   rd_val = irq_ie;
      default:   rd_val = UNMAPPED_READ;
    endcase
  end

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (commit) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r  <= req_t'(in_req_type);
      s1_addr_r <= in_reg_addr;
      s1_data_r <= in_write_data;
      s1_mc_r   <= in_machine_cycles;
      s1_dbl_r  <= in_double_speed;
      s1_ime_r  <= in_master_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_read_data_r  <= is_rd ? rd_val : 8'd0;
      out_irq_taken_r  <= irq_taken;
      out_irq_vector_r <= irq_vector;
      out_wake_r       <= irq_wake;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_irq_taken  = out_irq_taken_r;
  assign out_irq_vector = out_irq_vector_r;
  assign out_wake       = out_wake_r;

endmodule

`default_nettype wire
